### design/assert_macros.svh
// Assertion macros used by the resolver design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked at each rising edge outside reset.
`define COR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Checked at every rising edge, reset included.
`define COR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

### design/cor_pkg.sv
// Types and constants of the circle overlap resolver.
package cor_pkg;

  localparam int COORD_W  = 24;
  localparam int RAD_W    = 20;
  // Extra fraction bits carried by the distance.
  localparam int EXT_BITS = 8;

  localparam int RSUM_W = RAD_W + 1;
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQR_W  = 2 * RSUM_W;
  localparam int ROOT_W = RSUM_W + EXT_BITS;
  localparam int RADC_W = 2 * ROOT_W;
  localparam int QUO_W  = RSUM_W + 1;
  localparam int NUM_W  = SQR_W + EXT_BITS + 1;
  localparam int SUM_W  = COORD_W + 2;

  localparam int NUM_STAGES = 5 + ROOT_W + QUO_W;
  localparam int IDX_SQ0    = 2;
  localparam int IDX_DV0    = IDX_SQ0 + ROOT_W + 1;
  localparam int IDX_OUT    = NUM_STAGES - 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] mover_x;
    logic signed [COORD_W-1:0] mover_y;
    logic        [RAD_W-1:0]   mover_radius;
    logic signed [COORD_W-1:0] obstacle_x;
    logic signed [COORD_W-1:0] obstacle_y;
    logic        [RAD_W-1:0]   obstacle_radius;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
  } rsp_t;

  typedef struct packed {
    logic                      hit;
    logic                      neg_x;
    logic                      neg_y;
    logic signed [COORD_W-1:0] base_x;
    logic signed [COORD_W-1:0] base_y;
  } ctx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] mx;
    logic signed [COORD_W-1:0] my;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic                      neg_x;
    logic                      neg_y;
    logic                      near;
    logic        [RSUM_W-1:0]  adx;
    logic        [RSUM_W-1:0]  ady;
    logic        [RSUM_W-1:0]  rsum;
  } s1_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] mx;
    logic signed [COORD_W-1:0] my;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic                      neg_x;
    logic                      neg_y;
    logic                      near;
    logic        [SQR_W-1:0]   sqx;
    logic        [SQR_W-1:0]   sqy;
    logic        [SQR_W-1:0]   rr;
    logic        [SQR_W-1:0]   px;
    logic        [SQR_W-1:0]   py;
  } s2_t;

  typedef struct packed {
    ctx_t               ctx;
    logic [RADC_W-1:0]  rad;
    logic [ROOT_W-1:0]  root;
    logic [ROOT_W:0]    rem;
    logic [SQR_W-1:0]   px;
    logic [SQR_W-1:0]   py;
  } sq_t;

  typedef struct packed {
    ctx_t              ctx;
    logic [ROOT_W-1:0] len;
    logic [ROOT_W-1:0] rem_x;
    logic [ROOT_W-1:0] rem_y;
    logic [QUO_W-1:0]  lo_x;
    logic [QUO_W-1:0]  lo_y;
    logic [QUO_W-1:0]  q_x;
    logic [QUO_W-1:0]  q_y;
  } dv_t;

endpackage

### design/circle_overlap_resolve.sv
// Top level of the circle overlap resolver: a fully pipelined collision and push-out unit.
//
// Each req item carries a moving circle and an obstacle circle; each rsp item carries the
// hit flag and the resolved mover centre. Both channels use valid and ready, and an item
// moves at a rising edge where both are high.
//
// The datapath is a pipeline of 56 register stages: offset and range check, the squares and
// products, the hit compare, 29 stages of a bit-per-stage square root of the scaled squared
// distance, a stage that forms the rounded numerators, 22 stages of two restoring dividers
// working side by side (one quotient bit per stage), and the saturating output register.
// One item can enter in every cycle while the receiver holds rsp_ready high, so the sustained
// rate is then one item per cycle.
//
// Every stage has its own valid bit and loads when it is empty or when the stage after it
// loads, so a stalled receiver only holds the items that are packed behind the output; empty
// stages keep filling and req_ready stays high until every stage holds an item.
// Synchronous reset clears all valid bits; the data registers are not reset.
module circle_overlap_resolve
  import cor_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

`include "assert_macros.svh"

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] ld;

  s1_t s1;
  s2_t s2;
  sq_t sq [0:ROOT_W];
  dv_t dv [0:QUO_W];

  // One root bit per stage, two radicand bits consumed each time.
  function automatic sq_t sq_step(sq_t s);
    logic [ROOT_W+2:0] cur;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    sq_t o;
    o     = s;
    cur   = {s.rem, s.rad[RADC_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    diff  = cur - trial;
    if (cur >= trial) begin
      o.rem  = diff[ROOT_W:0];
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = cur[ROOT_W:0];
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    o.rad = {s.rad[RADC_W-3:0], 2'b00};
    return o;
  endfunction

  // Rounded numerators; the upper bits seed the remainder, which stays below the divisor.
  function automatic dv_t dv_prep(sq_t s);
    logic [NUM_W-1:0] nx;
    logic [NUM_W-1:0] ny;
    dv_t o;
    nx      = {1'b0, s.px, {EXT_BITS{1'b0}}} + NUM_W'(s.root >> 1);
    ny      = {1'b0, s.py, {EXT_BITS{1'b0}}} + NUM_W'(s.root >> 1);
    o.ctx   = s.ctx;
    o.len   = s.root;
    o.rem_x = nx[NUM_W-1 -: ROOT_W];
    o.rem_y = ny[NUM_W-1 -: ROOT_W];
    o.lo_x  = nx[QUO_W-1:0];
    o.lo_y  = ny[QUO_W-1:0];
    o.q_x   = '0;
    o.q_y   = '0;
    return o;
  endfunction

  // One quotient bit per stage for each axis.
  function automatic dv_t dv_step(dv_t s);
    logic [ROOT_W:0] cx;
    logic [ROOT_W:0] cy;
    logic [ROOT_W:0] dvs;
    logic [ROOT_W:0] dfx;
    logic [ROOT_W:0] dfy;
    logic            bx;
    logic            by;
    dv_t o;
    o   = s;
    dvs = {1'b0, s.len};
    cx  = {s.rem_x, s.lo_x[QUO_W-1]};
    cy  = {s.rem_y, s.lo_y[QUO_W-1]};
    dfx = cx - dvs;
    dfy = cy - dvs;
    bx  = (cx >= dvs);
    by  = (cy >= dvs);
    o.rem_x = bx ? dfx[ROOT_W-1:0] : cx[ROOT_W-1:0];
    o.rem_y = by ? dfy[ROOT_W-1:0] : cy[ROOT_W-1:0];
    o.lo_x  = {s.lo_x[QUO_W-2:0], 1'b0};
    o.lo_y  = {s.lo_y[QUO_W-2:0], 1'b0};
    o.q_x   = {s.q_x[QUO_W-2:0], bx};
    o.q_y   = {s.q_y[QUO_W-2:0], by};
    return o;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat(logic signed [SUM_W-1:0] v);
    logic [SUM_W-COORD_W:0] top;
    top = v[SUM_W-1:COORD_W-1];
    if ((&top) || (~|top)) begin
      return v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  // Push the mover out along the offset: out = obstacle - sign(d) * quotient.
  function automatic logic signed [COORD_W-1:0] place(logic signed [COORD_W-1:0] base,
                                                      logic neg, logic [QUO_W-1:0] q);
    logic signed [SUM_W-1:0] be;
    logic signed [SUM_W-1:0] qe;
    be = SUM_W'(base);
    qe = signed'(SUM_W'(q));
    return sat(neg ? be + qe : be - qe);
  endfunction

  // Stage load enables: a stage takes new data when it is empty or its content moves on.
  always_comb begin
    ld[IDX_OUT] = !vld[IDX_OUT] || rsp_ready;
    for (int k = IDX_OUT - 1; k >= 0; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign req_ready = ld[0];
  assign rsp_valid = vld[IDX_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= req_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ld[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Offset, magnitudes and the cheap box test that keeps the squares in range.
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic        [DIFF_W-1:0] adx;
  logic        [DIFF_W-1:0] ady;
  logic        [RSUM_W-1:0] rsum;

  always_comb begin
    dx   = DIFF_W'(req.obstacle_x) - DIFF_W'(req.mover_x);
    dy   = DIFF_W'(req.obstacle_y) - DIFF_W'(req.mover_y);
    adx  = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ady  = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    rsum = {1'b0, req.mover_radius} + {1'b0, req.obstacle_radius};
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1.mx    <= req.mover_x;
      s1.my    <= req.mover_y;
      s1.ox    <= req.obstacle_x;
      s1.oy    <= req.obstacle_y;
      s1.neg_x <= dx[DIFF_W-1];
      s1.neg_y <= dy[DIFF_W-1];
      s1.near  <= ((dx != '0) || (dy != '0)) &&
                  (adx <= DIFF_W'(rsum)) && (ady <= DIFF_W'(rsum));
      s1.adx   <= adx[RSUM_W-1:0];
      s1.ady   <= ady[RSUM_W-1:0];
      s1.rsum  <= rsum;
    end
  end

  // Squares for the hit test and the products for the numerators.
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2.mx    <= s1.mx;
      s2.my    <= s1.my;
      s2.ox    <= s1.ox;
      s2.oy    <= s1.oy;
      s2.neg_x <= s1.neg_x;
      s2.neg_y <= s1.neg_y;
      s2.near  <= s1.near;
      s2.sqx   <= s1.adx * s1.adx;
      s2.sqy   <= s1.ady * s1.ady;
      s2.rr    <= s1.rsum * s1.rsum;
      s2.px    <= s1.adx * s1.rsum;
      s2.py    <= s1.ady * s1.rsum;
    end
  end

  // Hit compare; the squared distance scaled by 2^16 seeds the root.
  logic [SQR_W:0] d2;
  logic           hit3;

  always_comb begin
    d2   = {1'b0, s2.sqx} + {1'b0, s2.sqy};
    hit3 = s2.near && (d2 <= {1'b0, s2.rr});
  end

  always_ff @(posedge clk) begin
    if (ld[IDX_SQ0]) begin
      sq[0].ctx.hit    <= hit3;
      sq[0].ctx.neg_x  <= s2.neg_x;
      sq[0].ctx.neg_y  <= s2.neg_y;
      sq[0].ctx.base_x <= hit3 ? s2.ox : s2.mx;
      sq[0].ctx.base_y <= hit3 ? s2.oy : s2.my;
      sq[0].rad        <= {d2[SQR_W-1:0], {(2*EXT_BITS){1'b0}}};
      sq[0].root       <= '0;
      sq[0].rem        <= '0;
      sq[0].px         <= s2.px;
      sq[0].py         <= s2.py;
    end
    for (int j = 1; j <= ROOT_W; j++) begin
      if (ld[IDX_SQ0 + j]) begin
        sq[j] <= sq_step(sq[j-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[IDX_DV0]) begin
      dv[0] <= dv_prep(sq[ROOT_W]);
    end
    for (int j = 1; j <= QUO_W; j++) begin
      if (ld[IDX_DV0 + j]) begin
        dv[j] <= dv_step(dv[j-1]);
      end
    end
  end

  // Output register; a miss passes the mover centre through untouched.
  always_ff @(posedge clk) begin
    if (ld[IDX_OUT]) begin
      rsp.hit   <= dv[QUO_W].ctx.hit;
      rsp.out_x <= dv[QUO_W].ctx.hit ?
                   place(dv[QUO_W].ctx.base_x, dv[QUO_W].ctx.neg_x, dv[QUO_W].q_x) :
                   dv[QUO_W].ctx.base_x;
      rsp.out_y <= dv[QUO_W].ctx.hit ?
                   place(dv[QUO_W].ctx.base_y, dv[QUO_W].ctx.neg_y, dv[QUO_W].q_y) :
                   dv[QUO_W].ctx.base_y;
    end
  end

  // The input only blocks once every stage is occupied.
  `COR_ASSERT(a_full_when_blocked, !req_ready |-> (&vld))
  // The root remainder never exceeds twice the root.
  `COR_ASSERT(a_root_rem, vld[IDX_DV0-1] |-> (sq[ROOT_W].rem <= {sq[ROOT_W].root, 1'b0}))
  // A hit is only flagged for pairs that passed the box test.
  `COR_ASSERT(a_hit_near, (ld[IDX_SQ0] && vld[IDX_SQ0-1]) |=> (!sq[0].ctx.hit || $past(s2.near)))
  // Reset leaves the pipeline empty.
  `COR_ASSERT_ALWAYS(a_reset_empty, rst |=> (vld == '0))

endmodule

### test/tb_circle_overlap_resolve.sv
// Testbench for the circle overlap resolver: random and directed circle pairs checked in order.
`timescale 1ns / 1ps

module tb_circle_overlap_resolve;
  import cor_pkg::*;

  localparam int LATENCY = 56;
  localparam longint CMAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  req_t pending_pairs[$];
  rsp_t resolved_centres[$];
  int errors = 0;
  int hits_seen = 0;
  int results_seen = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;
  bit quiet = 1'b0;

  circle_overlap_resolve dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #4 clk = ~clk;

  // Integer square root, bit by bit, of a value below 2^62.
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint push_amount(longint d, longint unsigned rsum,
                                         longint unsigned len16);
    longint unsigned mag, q;
    mag = d < 0 ? -d : d;
    q = (((mag * rsum) << 8) + (len16 >> 1)) / len16;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(longint v);
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v[COORD_W-1:0];
  endfunction

  // Predicts the resolved mover centre for one pair of circles.
  function automatic rsp_t resolve_pair(req_t r);
    rsp_t o;
    longint mx, my, ox, oy, dx, dy, rx, ry;
    longint unsigned rsum, adx, ady, d2, len16;
    mx = r.mover_x; my = r.mover_y; ox = r.obstacle_x; oy = r.obstacle_y;
    dx = ox - mx; dy = oy - my;
    rsum = r.mover_radius + r.obstacle_radius;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    rx = mx; ry = my;
    o.hit = 1'b0;
    if ((dx != 0 || dy != 0) && adx <= rsum && ady <= rsum) begin
      d2 = adx * adx + ady * ady;
      if (d2 <= rsum * rsum) begin
        len16 = root_floor(d2 << 16);
        o.hit = 1'b1;
        rx = ox - push_amount(dx, rsum, len16);
        ry = oy - push_amount(dy, rsum, len16);
      end
    end
    o.out_x = clamp_coord(rx);
    o.out_y = clamp_coord(ry);
    return o;
  endfunction

  function automatic req_t make_pair(longint mx, longint my, int mr,
                                     longint ox, longint oy, int orad);
    req_t r;
    r.mover_x = mx[COORD_W-1:0]; r.mover_y = my[COORD_W-1:0];
    r.mover_radius = mr[RAD_W-1:0];
    r.obstacle_x = ox[COORD_W-1:0]; r.obstacle_y = oy[COORD_W-1:0];
    r.obstacle_radius = orad[RAD_W-1:0];
    return r;
  endfunction

  // Mostly near pairs so that hits and pushes are common; the rest is raw noise.
  function automatic req_t random_pair();
    req_t r;
    logic [5*32-1:0] raw;
    int span, mr, orad;
    longint mx, my;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    if ($urandom_range(0, 9) < 7) begin
      span = 1 << $urandom_range(2, 20);
      mr = $urandom_range(0, span - 1);
      orad = $urandom_range(0, span - 1);
      mx = $signed(r.mover_x);
      my = $signed(r.mover_y);
      r = make_pair(mx, my, mr,
                    mx + $signed($urandom_range(0, 4 * span)) - 2 * span,
                    my + $signed($urandom_range(0, 4 * span)) - 2 * span, orad);
    end
    return r;
  endfunction

  // Driver: offers the head of the queue with random gaps; valid is held until taken.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        resolved_centres.push_back(resolve_pair(req));
        void'(pending_pairs.pop_front());
      end
      if ((req_valid && !req_ready) ||
          (pending_pairs.size() > 0 &&
           (quiet || $urandom_range(0, 99) >= 10))) begin
        req_valid <= 1'b1;
        req <= pending_pairs[0];
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result with the oldest prediction.
  always @(posedge clk) begin
    rsp_ready <= !rst && !hold_off && (quiet || $urandom_range(0, 99) >= 10);
    if (!rst && rsp_valid && rsp_ready) begin
      results_seen++;
      if (resolved_centres.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", rsp);
      end else begin
        if (rsp !== resolved_centres[0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %p, got %p", resolved_centres[0], rsp);
        end
        if (rsp.hit) hits_seen++;
        void'(resolved_centres.pop_front());
      end
    end
  end

  // Long receiver stall early on, so the pipeline fills and req_ready drops, then a
  // stretch with no idling on either side while items are still flowing.
  initial begin
    wait (!rst);
    repeat (300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
    repeat (100) @(posedge clk);
    quiet <= 1'b1;
    repeat (400) @(posedge clk);
    quiet <= 1'b0;
  end

  initial begin
    // Directed: same centre, exact touch, far apart, extreme fields, saturation.
    pending_pairs.push_back(make_pair(100, 200, 50, 100, 200, 50));
    pending_pairs.push_back(make_pair(0, 0, 256, 512, 0, 256));
    pending_pairs.push_back(make_pair(0, 0, 256, 513, 0, 256));
    pending_pairs.push_back(make_pair(0, 0, 300, 0, -400, 100));
    pending_pairs.push_back(make_pair(0, 0, 3, 3, 4, 2));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 1, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 1048575, 1, 1, 1048575));
    pending_pairs.push_back(make_pair(CMAX, CMAX, 1048575, CMAX - 1, CMAX, 1048575));
    pending_pairs.push_back(make_pair(CMIN, CMIN, 1048575, CMIN + 1, CMIN + 1, 1048575));
    pending_pairs.push_back(make_pair(CMIN, 0, 1048575, CMIN + 5, 0, 1048575));
    pending_pairs.push_back(make_pair(CMAX, CMIN, 1048575, CMIN, CMAX, 1048575));
    pending_pairs.push_back(make_pair(CMIN, CMAX, 0, CMAX, CMIN, 0));
    pending_pairs.push_back(make_pair(-1, -1, 1048575, 0, 0, 0));
    pending_pairs.push_back(make_pair(10, -10, 7, -10, 10, 30));
    pending_pairs.push_back(make_pair(CMAX, 0, 4, CMAX, 1, 4));
    for (int i = 0; i < 1400; i++) pending_pairs.push_back(random_pair());
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (pending_pairs.size() == 0 && !req_valid);
    wait (resolved_centres.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d results, %0d of them hits, across near, far and saturating pairs.",
             results_seen, hits_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### circle_overlap_resolve.f
+incdir+design
design/cor_pkg.sv
design/circle_overlap_resolve.sv
test/tb_circle_overlap_resolve.sv
